// ----- sv/rc4_pkg.sv -----
// rc4_pkg: shared types and constants for the RC4 stream cipher block.
// No dependencies; imported by every module of the block.

package rc4_pkg;

	localparam int BYTE_W        = 8;
	localparam int PERM_DEPTH    = 256;
	localparam int MAX_KEY_BYTES = 32;
	localparam int KEY_WORD_W    = 64;
	localparam int KEY_WORDS     = 4;
	localparam int KEY_LEN_W     = 6;
	localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
	localparam int CFG_IDX_W     = 3;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] key_t;

	localparam byte_t PERM_LAST = byte_t'(PERM_DEPTH - 1);

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd4;

	localparam logic MODE_KSA    = 1'b0;
	localparam logic MODE_CIPHER = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KS_J,
		ST_KS_W1,
		ST_KS_W2,
		ST_PR_J,
		ST_PR_T,
		ST_PR_OUT
	} state_t;

	// permutation RAM request: one read, one write, identity restore
	typedef struct packed {
		logic  re;
		byte_t raddr;
		logic  we;
		byte_t waddr;
		byte_t wdata;
		logic  clr;
	} sbox_req_t;

endpackage

// ----- sv/rc4_sbox.sv -----
// rc4_sbox: 256x8 permutation RAM, one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as their own address.
// Depends on rc4_pkg.

module rc4_sbox
	import rc4_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  sbox_req_t req,
	output byte_t     rdata
);

	byte_t                 mem [PERM_DEPTH];
	logic [PERM_DEPTH-1:0] vld_q;
	byte_t                 rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.clr) begin
			vld_q <= '0;
		end else if (req.we) begin
			vld_q[req.waddr] <= 1'b1;
		end
	end

	// write-first: a same-cycle write to the read address is forwarded
	always_ff @(posedge clk) begin
		if (req.re) begin
			if (req.clr) begin
				rdata_q <= req.raddr;
			end else if (req.we && (req.waddr == req.raddr)) begin
				rdata_q <= req.wdata;
			end else if (vld_q[req.raddr]) begin
				rdata_q <= mem[req.raddr];
			end else begin
				rdata_q <= req.raddr;
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/rc4_core.sv -----
// rc4_core: sequencer for key scheduling and keystream generation around one
// shared 8-bit three-operand adder. Depends on rc4_pkg and drives rc4_sbox.

module rc4_core
	import rc4_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 start_mode,
	input  byte_t                start_data,
	output logic                 idle,
	input  logic [KEY_LEN_W-1:0] key_len,
	input  key_t                 key_words,
	input  logic                 out_free,
	output logic                 res_valid,
	output byte_t                res_data,
	output sbox_req_t            sbox_req,
	input  byte_t                sbox_rdata
);

	state_t               state_q, state_d;
	byte_t                i_q, i_d;
	byte_t                j_q, j_d;
	byte_t                n_q, n_d;
	byte_t                sv_q, sv_d;
	byte_t                t_q, t_d;
	byte_t                data_q, data_d;
	logic [KEY_IDX_W-1:0] kidx_q, kidx_d;

	byte_t                add_a, add_b, add_c, add_sum;
	byte_t                key_byte;
	byte_t                ks;
	logic [KEY_LEN_W-1:0] len_eff, len_last;

	// shared adder
	assign add_sum = add_a + add_b + add_c;

	// length 0 acts as 1, anything above the key store saturates
	always_comb begin
		if (key_len == '0) begin
			len_eff = KEY_LEN_W'(1);
		end else if (key_len > KEY_LEN_W'(MAX_KEY_BYTES)) begin
			len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
		end else begin
			len_eff = key_len;
		end
	end
	assign len_last = len_eff - KEY_LEN_W'(1);

	assign key_byte = key_words[kidx_q[KEY_IDX_W-1:3]][{kidx_q[2:0], 3'b000} +: BYTE_W];

	// S[t] after the swap: S[j] is written only in the last state
	assign ks = (t_q == j_q) ? sv_q : sbox_rdata;

	assign idle     = (state_q == ST_IDLE);
	assign res_data = data_q ^ ks;

	always_comb begin
		state_d   = state_q;
		i_d       = i_q;
		j_d       = j_q;
		n_d       = n_q;
		sv_d      = sv_q;
		t_d       = t_q;
		data_d    = data_q;
		kidx_d    = kidx_q;
		add_a     = '0;
		add_b     = '0;
		add_c     = '0;
		res_valid = 1'b0;
		sbox_req  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (start_mode == MODE_KSA) begin
						sbox_req.clr   = 1'b1;
						sbox_req.re    = 1'b1;
						sbox_req.raddr = '0;
						j_d            = '0;
						n_d            = '0;
						kidx_d         = '0;
						state_d        = ST_KS_J;
					end else begin
						i_d            = i_q + byte_t'(1);
						sbox_req.re    = 1'b1;
						sbox_req.raddr = i_q + byte_t'(1);
						data_d         = start_data;
						state_d        = ST_PR_J;
					end
				end
			end
			ST_KS_J: begin
				add_a          = j_q;
				add_b          = sbox_rdata;
				add_c          = key_byte;
				sv_d           = sbox_rdata;
				j_d            = add_sum;
				sbox_req.re    = 1'b1;
				sbox_req.raddr = add_sum;
				state_d        = ST_KS_W1;
			end
			ST_KS_W1: begin
				sbox_req.we    = 1'b1;
				sbox_req.waddr = n_q;
				sbox_req.wdata = sbox_rdata;
				state_d        = ST_KS_W2;
			end
			ST_KS_W2: begin
				sbox_req.we    = 1'b1;
				sbox_req.waddr = j_q;
				sbox_req.wdata = sv_q;
				n_d            = n_q + byte_t'(1);
				kidx_d         = ({1'b0, kidx_q} == len_last) ? '0
				                 : kidx_q + KEY_IDX_W'(1);
				if (n_q == PERM_LAST) begin
					i_d     = '0;
					j_d     = '0;
					state_d = ST_IDLE;
				end else begin
					sbox_req.re    = 1'b1;
					sbox_req.raddr = n_q + byte_t'(1);
					state_d        = ST_KS_J;
				end
			end
			ST_PR_J: begin
				add_a          = j_q;
				add_b          = sbox_rdata;
				sv_d           = sbox_rdata;
				j_d            = add_sum;
				sbox_req.re    = 1'b1;
				sbox_req.raddr = add_sum;
				state_d        = ST_PR_T;
			end
			ST_PR_T: begin
				add_a          = sv_q;
				add_b          = sbox_rdata;
				t_d            = add_sum;
				sbox_req.we    = 1'b1;
				sbox_req.waddr = i_q;
				sbox_req.wdata = sbox_rdata;
				sbox_req.re    = 1'b1;
				sbox_req.raddr = add_sum;
				state_d        = ST_PR_OUT;
			end
			ST_PR_OUT: begin
				// rewriting S[j] while stalled is harmless
				sbox_req.we    = 1'b1;
				sbox_req.waddr = j_q;
				sbox_req.wdata = sv_q;
				if (out_free) begin
					res_valid = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q    <= n_d;
		sv_q   <= sv_d;
		t_q    <= t_d;
		data_q <= data_d;
		kidx_q <= kidx_d;
	end

endmodule

// ----- sv/rc4_stream_cipher.sv -----
// rc4_stream_cipher: top level of the RC4 stream cipher block.
// Holds the key registers and the output register; instantiates rc4_core and
// rc4_sbox. Depends on rc4_pkg.
//
//  channel | signals                                  | direction | notes
//  --------+------------------------------------------+-----------+-------------------------
//  in      | in_valid, in_ready, mode, data_in        | in        | mode 0 = key schedule
//  out     | out_valid, out_ready, data_out           | out       | one byte per mode-1 item
//  cfg     | cfg_we, cfg_index, cfg_data              | in        | write only, no wait
//
// Cipher byte: the core steps through ST_PR_J, ST_PR_T and ST_PR_OUT, and the
// result is registered into data_out; the next transfer waits for ST_IDLE. The
// steps follow the dependent read chain S[i], S[j], S[S[i]+S[j]] through the
// single read port of the permutation RAM. Key schedule: 256 swap steps, no
// result. Reset needs no clearing pass: per-entry valid bits make the RAM read
// as the identity until each entry is written; key scheduling clears them at once.
// A byte whose result finds the output register full waits in the core; the
// next input transfer is taken only after that byte has moved to the output.

module rc4_stream_cipher
	import rc4_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  logic [7:0]            data_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            data_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [KEY_WORD_W-1:0] cfg_data
);

	logic [KEY_LEN_W-1:0] key_len_q;
	key_t                 key_words_q;
	logic                 out_valid_q;
	byte_t                data_out_q;

	logic                 core_idle;
	logic                 core_res_valid;
	byte_t                core_res_data;
	logic                 out_free;
	sbox_req_t            sbox_req;
	byte_t                sbox_rdata;

	// config writes are expected only while idle; writes past the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q   <= KEY_LEN_W'(1);
			key_words_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_LENGTH: key_len_q      <= cfg_data[KEY_LEN_W-1:0];
				REG_KEY_WORD_0: key_words_q[0] <= cfg_data;
				REG_KEY_WORD_1: key_words_q[1] <= cfg_data;
				REG_KEY_WORD_2: key_words_q[2] <= cfg_data;
				REG_KEY_WORD_3: key_words_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = core_idle;

	// output slot frees in the same cycle its byte transfers
	assign out_free = !out_valid_q || out_ready;

	rc4_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_valid && core_idle),
		.start_mode (mode),
		.start_data (data_in),
		.idle       (core_idle),
		.key_len    (key_len_q),
		.key_words  (key_words_q),
		.out_free   (out_free),
		.res_valid  (core_res_valid),
		.res_data   (core_res_data),
		.sbox_req   (sbox_req),
		.sbox_rdata (sbox_rdata)
	);

	rc4_sbox u_sbox (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sbox_req),
		.rdata  (sbox_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res_valid) begin
			data_out_q <= core_res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;

endmodule

// ----- sv/rc4_checker.sv -----
// rc4_stream_cipher_sva: port-level assertions for rc4_stream_cipher, bound to the top.
// Depends on rc4_pkg for the mode codes.

module rc4_stream_cipher_sva
	import rc4_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       mode,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] data_out
);

	logic in_xfer;
	assign in_xfer = in_valid && in_ready;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out))
		else $error("data_out changed while stalled");

	// one item at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input taken while busy");

	// key scheduling never produces a byte
	a_ksa_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (mode == MODE_KSA) && !out_valid |=> !out_valid)
		else $error("result after key schedule");

	// a cipher byte into an empty output raises out_valid
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (mode == MODE_CIPHER) && !out_valid |-> ##4 out_valid)
		else $error("cipher result missing");

endmodule

bind rc4_stream_cipher rc4_stream_cipher_sva u_rc4_sva (.*);
